@@ design/assert_macros.svh @@
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/lsca_pkg.sv @@
// Shared types and constants for the LED strip command animator.
package lsca_pkg;
    localparam int LED_COUNT = 256;
    localparam int IDX_W = $clog2(LED_COUNT);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [7:0] CMD_BRIGHT = 8'd0;
    localparam logic [7:0] CMD_MODE = 8'd1;
    localparam logic [7:0] CMD_DELAY = 8'd2;
    localparam logic [7:0] CMD_SET_LED = 8'd3;
    localparam logic [7:0] CMD_SET_ALL = 8'd4;
    localparam logic [7:0] CMD_WIDTH = 8'd5;
    localparam logic [7:0] CMD_SHIFT = 8'd6;

    localparam logic [7:0] MODE_HUE_CYCLE = 8'd0;
    localparam logic [7:0] MODE_COMMAND = 8'd1;
    localparam logic [7:0] MODE_RANDOM = 8'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FILL,
        S_READ,
        S_OUT,
        S_STRIKE
    } state_t;

    typedef struct packed {
        logic [1:0] command_status;
        logic       frame_advanced;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [7:0] current_mode;
        logic [7:0] brightness_limit;
    } result_t;

    // Seven-color table.
    function automatic logic [23:0] palette(input logic [2:0] i);
        logic [23:0] c;
        unique case (i)
            3'd0: c = 24'hFF0000;
            3'd1: c = 24'hFF7D00;
            3'd2: c = 24'hFFFF00;
            3'd3: c = 24'h00FF00;
            3'd4: c = 24'h00FFFF;
            3'd5: c = 24'h0000FF;
            3'd6: c = 24'hFF00FF;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    // Remainder by seven of a 9-bit value via folding of octal digits.
    function automatic logic [2:0] mod7(input logic [8:0] v);
        logic [4:0] s;
        logic [3:0] t;
        s = {2'b0, v[8:6]} + {2'b0, v[5:3]} + {2'b0, v[2:0]};
        t = {1'b0, s[4:3]} + {1'b0, s[2:0]};
        if (t >= 4'd7) t = t - 4'd7;
        if (t >= 4'd7) t = t - 4'd7;
        return t[2:0];
    endfunction
endpackage

@@ design/lsca_stream_if.sv @@
// Valid/ready channel interface carrying a generic payload.
interface lsca_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/lsca_in_if.sv @@
// Input item channel: op, serial byte, random byte and LED index.
interface lsca_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] byte_value;
    logic [7:0] random_value;
    logic [7:0] led_index;
    modport source (output valid, output op, output byte_value, output random_value,
                    output led_index, input ready);
    modport sink (input valid, input op, input byte_value, input random_value,
                  input led_index, output ready);
endinterface

@@ design/lsca_out_if.sv @@
// Result item channel.
interface lsca_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] command_status;
    logic       frame_advanced;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] current_mode;
    logic [7:0] brightness_limit;
    modport source (output valid, output command_status, output frame_advanced,
                    output red_level, output green_level, output blue_level,
                    output current_mode, output brightness_limit, input ready);
    modport sink (input valid, input command_status, input frame_advanced,
                  input red_level, input green_level, input blue_level,
                  input current_mode, input brightness_limit, output ready);
endinterface

@@ design/lsca_led_ram.sv @@
// Single-port LED color memory with registered read data.
module lsca_led_ram
    import lsca_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] addr,
    input  logic [23:0]      wdata,
    output logic [23:0]      rdata
);
    logic [23:0] mem [LED_COUNT];

    // One access per cycle; read returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ design/led_strip_command_animator.sv @@
// Top level of the LED strip command animator.
// Each transfer on in_ch yields one result on out_ch, and the next input transfer is
// taken once that result transfer has completed. The result is registered through
// S_OUT for serial bytes and ticks that run no memory walk, and through S_READ and
// then S_OUT for an LED read. A frame tick that shifts walks the strip from the top
// entry down through the single LED memory port, each LED read and then written.
// A random frame first works out, bit by bit, the remainder that decides the seed.
// A fill walks up from entry zero, and a shift followed by a fill runs the shift
// walk first. After reset the memory is cleared by a pass over all 256 entries
// during which no item is accepted. A strike_length write takes effect at the next
// random frame.
module led_strip_command_animator
    import lsca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    lsca_in_if.sink  in_ch,
    lsca_out_if.source out_ch,
    lsca_stream_if.sink cfg
);
    `include "assert_macros.svh"

    state_t state_reg, state_next;
    logic             parser_busy_reg, parser_busy_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       args_reg [4];
    logic [7:0]       args_next [4];
    logic [2:0]       argc_reg, argc_next;
    logic [2:0]       expc_reg, expc_next;
    logic [7:0]       mode_reg, mode_next;
    logic [7:0]       width_reg, width_next;
    logic [7:0]       delay_reg, delay_next;
    logic [7:0]       bright_reg, bright_next;
    logic             shiftp_reg, shiftp_next;
    logic             fillp_reg, fillp_next;
    logic [23:0]      fillc_reg, fillc_next;
    logic [7:0]       rstep_reg, rstep_next;
    logic [7:0]       strike_reg, strike_next;
    logic [7:0]       tick_reg, tick_next;
    logic [7:0]       slen_reg;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic             seed_reg, seed_next;
    logic [23:0]      seedc_reg, seedc_next;
    logic             post_fill_reg, post_fill_next;
    logic [7:0]       dvd_reg, dvd_next;
    logic [7:0]       dvs_reg, dvs_next;
    logic [7:0]       rem_reg, rem_next;
    logic [2:0]       bitc_reg, bitc_next;
    result_t          res_reg, res_next;
    logic             ovalid_reg, ovalid_next;

    logic             we;
    logic [IDX_W-1:0] addr;
    logic [23:0]      wdata, rdata;

    lsca_led_ram u_ram (.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

    logic [CNT_W-1:0] act_w;
    logic [7:0]       slen_eff;
    logic [7:0]       tick_inc;
    logic [7:0]       rstep_inc;
    logic [8:0]       rstep_p1;

    assign act_w = (CNT_W'(width_reg) > CNT_W'(LED_COUNT)) ? CNT_W'(LED_COUNT)
                                                          : CNT_W'(width_reg);
    assign slen_eff = (slen_reg == 8'd0) ? 8'd1 : slen_reg;
    assign tick_inc = tick_reg + 8'd1;
    assign rstep_inc = rstep_reg + 8'd1;
    assign rstep_p1 = {1'b0, rstep_inc} + 9'd1;

    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg.ready = 1'b1;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.command_status = res_reg.command_status;
    assign out_ch.frame_advanced = res_reg.frame_advanced;
    assign out_ch.red_level = res_reg.red_level;
    assign out_ch.green_level = res_reg.green_level;
    assign out_ch.blue_level = res_reg.blue_level;
    assign out_ch.current_mode = res_reg.current_mode;
    assign out_ch.brightness_limit = res_reg.brightness_limit;

    // Strike length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slen_reg <= 8'd10;
        end
        else if (cfg.valid && cfg.ready)
        begin
            slen_reg <= cfg.data;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            parser_busy_reg <= 1'b0;
            code_reg <= 8'd0;
            argc_reg <= 3'd0;
            expc_reg <= 3'd0;
            mode_reg <= MODE_RANDOM;
            width_reg <= 8'd100;
            delay_reg <= 8'd20;
            bright_reg <= 8'd30;
            shiftp_reg <= 1'b0;
            fillp_reg <= 1'b0;
            fillc_reg <= 24'd0;
            rstep_reg <= 8'd0;
            strike_reg <= 8'd0;
            tick_reg <= 8'd0;
            ptr_reg <= '0;
            lim_reg <= '0;
            seed_reg <= 1'b0;
            post_fill_reg <= 1'b0;
            dvd_reg <= 8'd0;
            dvs_reg <= 8'd1;
            rem_reg <= 8'd0;
            bitc_reg <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            parser_busy_reg <= parser_busy_next;
            code_reg <= code_next;
            argc_reg <= argc_next;
            expc_reg <= expc_next;
            mode_reg <= mode_next;
            width_reg <= width_next;
            delay_reg <= delay_next;
            bright_reg <= bright_next;
            shiftp_reg <= shiftp_next;
            fillp_reg <= fillp_next;
            fillc_reg <= fillc_next;
            rstep_reg <= rstep_next;
            strike_reg <= strike_next;
            tick_reg <= tick_next;
            ptr_reg <= ptr_next;
            lim_reg <= lim_next;
            seed_reg <= seed_next;
            post_fill_reg <= post_fill_next;
            dvd_reg <= dvd_next;
            dvs_reg <= dvs_next;
            rem_reg <= rem_next;
            bitc_reg <= bitc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        args_reg <= args_next;
        seedc_reg <= seedc_next;
        res_reg <= res_next;
    end

    // Sequencer: parser, frame engine and memory walks.
    always_comb
    begin
        logic [1:0] st;
        logic [8:0] trial;
        logic [8:0] diff;
        st = ST_NONE;
        trial = '0;
        diff = '0;
        state_next = state_reg;
        parser_busy_next = parser_busy_reg;
        code_next = code_reg;
        args_next = args_reg;
        argc_next = argc_reg;
        expc_next = expc_reg;
        mode_next = mode_reg;
        width_next = width_reg;
        delay_next = delay_reg;
        bright_next = bright_reg;
        shiftp_next = shiftp_reg;
        fillp_next = fillp_reg;
        fillc_next = fillc_reg;
        rstep_next = rstep_reg;
        strike_next = strike_reg;
        tick_next = tick_reg;
        ptr_next = ptr_reg;
        lim_next = lim_reg;
        seed_next = seed_reg;
        seedc_next = seedc_reg;
        post_fill_next = post_fill_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        bitc_next = bitc_reg;
        res_next = res_reg;
        ovalid_next = ovalid_reg;
        we = 1'b0;
        addr = ptr_reg[IDX_W-1:0];
        wdata = 24'd0;

        // Result transfer completes.
        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                wdata = 24'd0;
                ptr_next = ptr_reg + CNT_W'(1);
                if (ptr_reg == CNT_W'(LED_COUNT - 1))
                begin
                    ptr_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    res_next.command_status = ST_NONE;
                    res_next.frame_advanced = 1'b0;
                    res_next.red_level = 8'd0;
                    res_next.green_level = 8'd0;
                    res_next.blue_level = 8'd0;
                    state_next = S_OUT;
                    priority if (in_ch.op == OP_BYTE)
                    begin
                        if (!parser_busy_reg)
                        begin
                            code_next = in_ch.byte_value;
                            argc_next = 3'd0;
                            expc_next = (in_ch.byte_value == CMD_SET_LED) ? 3'd4 :
                                        (in_ch.byte_value == CMD_SET_ALL) ? 3'd3 : 3'd1;
                            parser_busy_next = 1'b1;
                        end
                        else
                        begin
                            args_next[argc_reg[1:0]] = in_ch.byte_value;
                            argc_next = argc_reg + 3'd1;
                            if (argc_next == expc_reg)
                            begin
                                parser_busy_next = 1'b0;
                                st = ST_EXEC;
                                unique case (code_reg)
                                    CMD_BRIGHT: bright_next = args_next[0];
                                    CMD_MODE: mode_next = args_next[0];
                                    CMD_DELAY: delay_next = args_next[0];
                                    CMD_WIDTH: width_next = args_next[0];
                                    CMD_SET_LED:
                                    begin
                                        mode_next = MODE_COMMAND;
                                        we = 1'b1;
                                        addr = args_next[0][IDX_W-1:0];
                                        wdata = {args_next[1], args_next[2], args_next[3]};
                                    end
                                    CMD_SET_ALL:
                                    begin
                                        mode_next = MODE_COMMAND;
                                        fillc_next = {args_next[0], args_next[1],
                                                      args_next[2]};
                                        fillp_next = 1'b1;
                                    end
                                    CMD_SHIFT: shiftp_next = 1'b1;
                                    default: st = ST_UNKNOWN;
                                endcase
                            end
                        end
                    end
                    else if (in_ch.op == OP_TICK)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= ((delay_reg == 8'd0) ? 8'd1 : delay_reg))
                        begin
                            tick_next = 8'd0;
                            res_next.frame_advanced = 1'b1;
                            seed_next = 1'b0;
                            post_fill_next = 1'b0;
                            lim_next = act_w;
                            ptr_next = (act_w > CNT_W'(1)) ? act_w - CNT_W'(1) : '0;
                            unique case (mode_reg)
                                MODE_HUE_CYCLE:
                                begin
                                    // Write the entering color, shift, then overwrite.
                                    rstep_next = rstep_inc;
                                    we = 1'b1;
                                    addr = '0;
                                    wdata = palette(mod7({1'b0, rstep_inc}));
                                    seed_next = 1'b1;
                                    seedc_next = palette(mod7(rstep_p1));
                                    state_next = S_SHIFT_RD;
                                end
                                MODE_COMMAND:
                                begin
                                    if (shiftp_reg)
                                    begin
                                        shiftp_next = 1'b0;
                                        post_fill_next = fillp_reg;
                                        state_next = S_SHIFT_RD;
                                    end
                                    else if (fillp_reg)
                                    begin
                                        ptr_next = '0;
                                        state_next = S_FILL;
                                    end
                                    if (fillp_reg)
                                    begin
                                        fillp_next = 1'b0;
                                    end
                                end
                                MODE_RANDOM:
                                begin
                                    // The seed test needs the old counter modulo the
                                    // strike length, worked out bit by bit first.
                                    strike_next = strike_reg + 8'd1;
                                    dvd_next = strike_reg;
                                    dvs_next = slen_eff;
                                    rem_next = 8'd0;
                                    bitc_next = 3'd7;
                                    seedc_next = palette(mod7({1'b0, in_ch.random_value}));
                                    state_next = S_STRIKE;
                                end
                                default: mode_next = MODE_HUE_CYCLE;
                            endcase
                        end
                    end
                    else if (in_ch.op == OP_READ)
                    begin
                        addr = in_ch.led_index[IDX_W-1:0];
                        state_next = S_READ;
                    end
                    else
                    begin
                        // The unused op changes nothing.
                        state_next = S_OUT;
                    end
                    res_next.command_status = st;
                    res_next.current_mode = mode_next;
                    res_next.brightness_limit = bright_next;
                end
            end
            S_STRIKE:
            begin
                // One restoring remainder step per cycle, most significant bit first.
                trial = {rem_reg, dvd_reg[7]};
                diff = trial - {1'b0, dvs_reg};
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = diff[7:0];
                end
                else
                begin
                    rem_next = trial[7:0];
                end
                dvd_next = {dvd_reg[6:0], 1'b0};
                bitc_next = bitc_reg - 3'd1;
                if (bitc_reg == 3'd0)
                begin
                    seed_next = (rem_next == 8'd0);
                    state_next = S_SHIFT_RD;
                end
            end
            S_READ:
            begin
                res_next.red_level = rdata[23:16];
                res_next.green_level = rdata[15:8];
                res_next.blue_level = rdata[7:0];
                state_next = S_OUT;
            end
            S_SHIFT_RD:
            begin
                // Read entry ptr-1; at the bottom finish with the seed write.
                if (ptr_reg == '0)
                begin
                    if (seed_reg)
                    begin
                        we = 1'b1;
                        addr = '0;
                        wdata = seedc_reg;
                    end
                    if (post_fill_reg)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    addr = IDX_W'(ptr_reg - CNT_W'(1));
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                we = 1'b1;
                wdata = rdata;
                ptr_next = ptr_reg - CNT_W'(1);
                state_next = S_SHIFT_RD;
            end
            S_FILL:
            begin
                if (ptr_reg >= lim_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    we = 1'b1;
                    wdata = fillc_reg;
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_OUT)
        begin
            post_fill_next = 1'b0;
        end
    end

    `CHK_IMPLY(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ch.ready, "input accepted while a walk is in progress")
    `CHK_NEXT(a_out_follows, clk, rst_n, state_reg == S_OUT, out_ch.valid, "result not presented after completion")
    `CHK_IMPLY(a_argc_bound, clk, rst_n, parser_busy_reg, argc_reg < expc_reg, "argument count passed expected count")
    `CHK_IMPLY(a_rem_bound, clk, rst_n, state_reg == S_STRIKE, rem_reg < dvs_reg, "strike remainder not below divisor")
endmodule
